// ===== design/bf3_pkg.sv =====
// shared types and constants for the 3x3 rgb box filter
// used by every module of the block but bf3_ram; depends on nothing

package bf3_pkg;

  // field widths
  localparam int CHAN_W         = 8;
  localparam int PIX_W          = 3 * CHAN_W;
  localparam int IMAGE_WIDTH_W  = 12;
  localparam int IMAGE_HEIGHT_W = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // op codes of an input word
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // frame geometry
  localparam int MIN_DIM            = 3;
  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;
  localparam int MAX_WIDTH_DEFAULT  = 2048;

  // output queue; five entries cover the pipeline at full rate
  localparam int OUT_DEPTH_DEFAULT = 8;

  // divide by nine: floor(x / 9) == (x * 7282) >> 16 for every x up to 9 * 255
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // window taps per lane
  localparam int TAPS = 9;

  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } pix_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;
  } res_word_t;

  // what travels beside the window through the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic frame_end;
  } res_meta_t;

endpackage

// ===== design/bf3_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// uses no package

module bf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bf3_lane.sv =====
// one color lane: sum of the nine window taps, then divide by nine
// depends on bf3_pkg; two register stages from taps to mean

module bf3_lane (
  input  logic                      clk,
  input  logic [bf3_pkg::CHAN_W-1:0] taps [bf3_pkg::TAPS],
  output logic [bf3_pkg::CHAN_W-1:0] mean
);

  logic [bf3_pkg::SUM_W-1:0]  row_sum [3];
  logic [bf3_pkg::SUM_W-1:0]  sum_comb;
  logic [bf3_pkg::SUM_W-1:0]  sum;
  logic [bf3_pkg::PROD_W-1:0] prod;

  // adder tree: three row sums, then the total
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = bf3_pkg::SUM_W'(taps[3*r]) + bf3_pkg::SUM_W'(taps[3*r+1])
                 + bf3_pkg::SUM_W'(taps[3*r+2]);
    end
    sum_comb = row_sum[0] + row_sum[1] + row_sum[2];
  end

  always_ff @(posedge clk) begin
    sum <= sum_comb;
  end

  // reciprocal multiply in place of the divider
  always_ff @(posedge clk) begin
    prod <= bf3_pkg::PROD_W'(sum) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_NINE);
  end

  assign mean = prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::CHAN_W];

endmodule

// ===== design/bf3_fifo.sv =====
// output word queue in registers, parts the pipeline from the result port
// depends on bf3_pkg for the result word type

module bf3_fifo #(
  parameter int DEPTH = bf3_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bf3_pkg::res_word_t         push_word,
  output logic                       result_valid,
  input  logic                       result_ready,
  output bf3_pkg::res_word_t         result,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bf3_pkg::res_word_t mem [DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic               pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = count != '0;
  assign result       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // the credit check upstream must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == CW'(DEPTH)))
    else $error("output queue overflow");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> rd_ptr == wr_ptr)
    else $error("empty queue with unequal pointers");

endmodule

// ===== design/box_filter_3x3_rgb.sv =====
// 3x3 rgb mean filter over a raster pixel stream, top level
// depends on bf3_pkg, bf3_ram, bf3_lane and bf3_fifo
//
// Takes one word per clock, pixel or flush, with no bubbles while the result side keeps up;
// pixel_ready drops only when the output queue, counted with the words still in the pipeline,
// is full. The word that releases a result is image_width + 1 pixels after the pixel at the
// window center; results pass the window and lane registers. Two line buffers of MAX_WIDTH
// entries (block rams) feed the window; a line buffer read that hits the entry written in the
// same clock is forwarded. Three lanes, one per color, sum the window and divide by nine with a
// reciprocal multiply; a merge stage chooses the passthrough pixel at the frame border and marks
// the last pixel of the frame. After reset or a register write the first image_width + 1 pixels
// give no result; flush words drain the last row and pixel. Registers are to be written
// only while the block is idle; the block does not enforce it. Every write restarts the frame.

module box_filter_3x3_rgb #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEFAULT,
  parameter int OUT_DEPTH = bf3_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  bf3_pkg::pix_word_t               pixel,
  output logic                             result_valid,
  input  logic                             result_ready,
  output bf3_pkg::res_word_t               result,
  input  logic                             cfg_wr_en,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int LW  = $clog2(MAX_WIDTH + 2);
  localparam int HW  = bf3_pkg::IMAGE_HEIGHT_W;
  localparam int PW  = bf3_pkg::PIX_W;
  localparam int QW  = $clog2(OUT_DEPTH + 1);
  localparam int KW  = QW + 1;
  localparam int WIDTH_RESET = (bf3_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                               MAX_WIDTH : bf3_pkg::IMAGE_WIDTH_RESET;

  // registers and position counters
  logic [WW-1:0] width;
  logic [HW-1:0] height;
  logic [CW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic [CW-1:0] out_col;
  logic [HW-1:0] out_row;
  logic [LW-1:0] lag;

  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;
  logic [CW-1:0] in_col_next;
  logic [HW-1:0] in_row_next;
  logic [CW-1:0] out_col_next;
  logic [HW-1:0] out_row_next;
  logic [LW-1:0] lag_next;

  logic [bf3_pkg::IMAGE_WIDTH_W-1:0] cfg_w_raw;
  logic [HW-1:0]                     cfg_h_raw;

  logic          accept;
  logic          is_flush;
  logic          lag_zero;
  logic          lag_full;
  logic          do_shift;
  logic          do_emit;
  logic [WW:0]   width_plus1;
  logic [CW:0]   in_col_inc;
  logic [CW:0]   out_col_inc;
  logic [HW:0]   in_row_inc;
  logic [HW:0]   out_row_inc;
  logic [CW-1:0] buf_idx;
  logic [PW-1:0] new_pix;
  bf3_pkg::res_meta_t meta0;

  // stage 1: line buffer read data arrives
  logic               s1_valid;
  logic               s1_hit;
  logic [CW-1:0]      s1_addr;
  logic [PW-1:0]      s1_pix;
  bf3_pkg::res_meta_t s1_meta;

  logic [PW-1:0] upper_rd;
  logic [PW-1:0] middle_rd;
  logic [PW-1:0] up_eff;
  logic [PW-1:0] mid_eff;
  logic [PW-1:0] fwd_up;
  logic [PW-1:0] fwd_mid;

  logic [PW-1:0] win [3][3];

  // stages 2 to 4 beside the lanes
  bf3_pkg::res_meta_t s2_meta;
  bf3_pkg::res_meta_t s3_meta;
  bf3_pkg::res_meta_t s4_meta;
  logic [PW-1:0]      s3_center;
  logic [PW-1:0]      s4_center;

  logic [bf3_pkg::CHAN_W-1:0] lane_taps [3][bf3_pkg::TAPS];
  logic [bf3_pkg::CHAN_W-1:0] lane_mean [3];

  bf3_pkg::res_word_t merged;
  logic [QW-1:0]      queue_count;
  logic [KW-1:0]      in_flight;

  // decode of the incoming word
  assign accept      = pixel_valid && pixel_ready;
  assign is_flush    = pixel.op == bf3_pkg::OP_FLUSH;
  assign width_plus1 = {1'b0, width} + (WW+1)'(1);
  assign lag_zero    = lag == '0;
  assign lag_full    = (WW+1)'(lag) == width_plus1;
  assign do_shift    = !is_flush || !lag_zero;
  assign do_emit     = is_flush ? !lag_zero : lag_full;
  assign in_col_inc  = {1'b0, in_col} + (CW+1)'(1);
  assign out_col_inc = {1'b0, out_col} + (CW+1)'(1);
  assign in_row_inc  = {1'b0, in_row} + (HW+1)'(1);
  assign out_row_inc = {1'b0, out_row} + (HW+1)'(1);
  assign new_pix     = is_flush ? '0 : {pixel.in_red, pixel.in_green, pixel.in_blue};

  // line buffer column: input column for a pixel, next output column for a flush
  always_comb begin
    if (!is_flush) begin
      buf_idx = in_col;
    end else if (out_col_inc >= (CW+1)'(width)) begin
      buf_idx = '0;
    end else begin
      buf_idx = out_col_inc[CW-1:0];
    end
  end

  // border and frame end come from the output position before it moves
  always_comb begin
    meta0.emit      = do_emit;
    meta0.border    = out_row == '0 || out_row_inc >= (HW+1)'(height) ||
                      out_col == '0 || out_col_inc >= (CW+1)'(width);
    meta0.frame_end = out_row_inc >= (HW+1)'(height) &&
                      out_col_inc >= (CW+1)'(width);
  end

  // register writes, clamped to the legal range; width takes only the low IMAGE_WIDTH_W data bits
  assign cfg_w_raw = cfg_data[bf3_pkg::IMAGE_WIDTH_W-1:0];
  assign cfg_h_raw = cfg_data[HW-1:0];

  always_comb begin
    width_next  = width;
    height_next = height;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        bf3_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_w_raw < bf3_pkg::IMAGE_WIDTH_W'(bf3_pkg::MIN_DIM)) begin
            width_next = WW'(bf3_pkg::MIN_DIM);
          end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
            width_next = WW'(MAX_WIDTH);
          end else begin
            width_next = WW'(cfg_w_raw);
          end
        end
        bf3_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_h_raw < HW'(bf3_pkg::MIN_DIM)) begin
            height_next = HW'(bf3_pkg::MIN_DIM);
          end else begin
            height_next = cfg_h_raw;
          end
        end
        default: begin
          width_next  = width;
          height_next = height;
        end
      endcase
    end
  end

  // position counters and the input to output lag
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    lag_next     = lag;
    if (cfg_wr_en) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
      lag_next     = '0;
    end else if (accept) begin
      if (!is_flush) begin
        if (in_col_inc >= (CW+1)'(width)) begin
          in_col_next = '0;
          in_row_next = (in_row_inc >= (HW+1)'(height)) ? '0 : in_row_inc[HW-1:0];
        end else begin
          in_col_next = in_col_inc[CW-1:0];
        end
        if (!lag_full) begin
          lag_next = lag + LW'(1);
        end
      end else if (!lag_zero) begin
        lag_next = lag - LW'(1);
      end
      if (do_emit) begin
        if (out_col_inc >= (CW+1)'(width)) begin
          out_col_next = '0;
          out_row_next = (out_row_inc >= (HW+1)'(height)) ? '0 : out_row_inc[HW-1:0];
        end else begin
          out_col_next = out_col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= WW'(WIDTH_RESET);
      height  <= HW'(bf3_pkg::IMAGE_HEIGHT_RESET);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lag     <= '0;
    end else begin
      width   <= width_next;
      height  <= height_next;
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      lag     <= lag_next;
    end
  end

  // stage 1 control; a hit means the word in stage 1 writes the column just read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_hit   <= 1'b0;
      s1_meta  <= '0;
    end else begin
      s1_valid <= accept && do_shift;
      s1_hit   <= accept && do_shift && s1_valid && s1_addr == buf_idx;
      s1_meta  <= meta0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= buf_idx;
      s1_pix  <= new_pix;
    end
  end

  // line buffers: upper row and middle row
  bf3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_upper_row (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (mid_eff),
    .rd_en   (accept),
    .rd_addr (buf_idx),
    .rd_data (upper_rd)
  );

  bf3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_middle_row (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (s1_pix),
    .rd_en   (accept),
    .rd_addr (buf_idx),
    .rd_data (middle_rd)
  );

  // forward the values written in the previous cycle to the same column
  assign up_eff  = s1_hit ? fwd_up : upper_rd;
  assign mid_eff = s1_hit ? fwd_mid : middle_rd;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_up  <= mid_eff;
      fwd_mid <= s1_pix;
    end
  end

  // 3x3 window shifts left, new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_eff;
      win[1][2] <= mid_eff;
      win[2][2] <= s1_pix;
    end
  end

  // color lanes: lane 0 blue, lane 1 green, lane 2 red
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          lane_taps[ch][3*r+c] = win[r][c][ch*bf3_pkg::CHAN_W +: bf3_pkg::CHAN_W];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bf3_lane u_lane (
      .clk  (clk),
      .taps (lane_taps[ch]),
      .mean (lane_mean[ch])
    );
  end

  // word info beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_meta <= '0;
      s3_meta <= '0;
      s4_meta <= '0;
    end else begin
      s2_meta      <= s1_meta;
      s2_meta.emit <= s1_valid && s1_meta.emit;
      s3_meta      <= s2_meta;
      s4_meta      <= s3_meta;
    end
  end

  always_ff @(posedge clk) begin
    s3_center <= win[1][1];
    s4_center <= s3_center;
  end

  // merge: passthrough at the border, lane means inside
  always_comb begin
    if (s4_meta.border) begin
      merged.out_red   = s4_center[2*bf3_pkg::CHAN_W +: bf3_pkg::CHAN_W];
      merged.out_green = s4_center[bf3_pkg::CHAN_W +: bf3_pkg::CHAN_W];
      merged.out_blue  = s4_center[0 +: bf3_pkg::CHAN_W];
    end else begin
      merged.out_red   = lane_mean[2];
      merged.out_green = lane_mean[1];
      merged.out_blue  = lane_mean[0];
    end
    merged.frame_end = s4_meta.frame_end;
  end

  bf3_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (s4_meta.emit),
    .push_word    (merged),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .count        (queue_count)
  );

  // credit: words queued plus results still in the pipeline
  assign in_flight = KW'(queue_count) + KW'(s1_valid && s1_meta.emit) + KW'(s2_meta.emit)
                   + KW'(s3_meta.emit) + KW'(s4_meta.emit);
  assign pixel_ready = in_flight < KW'(OUT_DEPTH);

  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    (WW+1)'(lag) <= width_plus1)
    else $error("lag beyond one row plus one pixel");

  a_out_pos: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(out_col) < (CW+1)'(width) && out_row < height)
    else $error("output position outside the frame");

  a_fwd_hit: assert property (@(posedge clk) disable iff (rst)
    s1_hit |-> $past(s1_valid) && s1_addr == $past(s1_addr))
    else $error("forward taken without a write to the same column");

  a_steady_lag: assert property (@(posedge clk) disable iff (rst)
    accept && !is_flush && lag_full && !cfg_wr_en |=> lag == $past(lag))
    else $error("lag moved on a steady pixel");

endmodule
